### rtl/zbpc_pkg.sv
// Shared constants and opcodes for the z-buffer pixel compositor.
package zbpc_pkg;

	// Frame geometry limits and storage layout
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int BUF_STRIDE = ((MAX_WIDTH + 3) / 4) * 4;
	localparam int BUF_SIZE   = BUF_STRIDE * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(BUF_SIZE);

	// Field widths
	localparam int DIM_W    = 9;
	localparam int COORD_W  = 8;
	localparam int COLOR_W  = 8;
	localparam int DEPTH_W  = 16;
	localparam int OP_W     = 2;
	localparam int CFG_IDX_W = 4;
	localparam int PROD_W   = 2 * DIM_W + 2;

	// Pixel operations
	localparam logic [OP_W-1:0] OP_FILL  = 2'd0;
	localparam logic [OP_W-1:0] OP_DEPTH = 2'd1;
	localparam logic [OP_W-1:0] OP_FLAT  = 2'd2;
	localparam logic [OP_W-1:0] OP_READ  = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

	// Reset values of the frame size registers
	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 9'd256;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 9'd256;

endpackage

### rtl/zbpc_if.sv
// Request, response and configuration channel interfaces.
interface zbpc_req_if;
	logic                          valid;
	logic                          ready;
	logic [zbpc_pkg::OP_W-1:0]     opcode;
	logic [zbpc_pkg::COORD_W-1:0]  x_pos;
	logic [zbpc_pkg::COORD_W-1:0]  y_pos;
	logic [zbpc_pkg::COLOR_W-1:0]  src_color;
	logic [zbpc_pkg::DEPTH_W-1:0]  depth_value;

	modport source (output valid, opcode, x_pos, y_pos, src_color, depth_value, input ready);
	modport sink   (input valid, opcode, x_pos, y_pos, src_color, depth_value, output ready);
endinterface

interface zbpc_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [zbpc_pkg::COLOR_W-1:0]  pixel_color;
	logic [zbpc_pkg::DEPTH_W-1:0]  pixel_depth;
	logic                          was_written;
	logic                          out_of_range;

	modport source (output valid, pixel_color, pixel_depth, was_written, out_of_range,
		input ready);
	modport sink   (input valid, pixel_color, pixel_depth, was_written, out_of_range,
		output ready);
endinterface

interface zbpc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [zbpc_pkg::CFG_IDX_W-1:0]  index;
	logic [zbpc_pkg::DIM_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/zbpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module zbpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/zbuffer_pixel_compositor.sv
// An accepted request waits in stage 1, then commits into the response register.
// Throughput: one request per cycle unless rsp.ready stalls; the read-modify-write
// on the frame RAMs closes through a one-entry forward of the write made at load.
// Reset: arst_n clears the pipeline valids, the forward entry and sets the
// frame size to 256 x 256; the color and depth RAMs are not cleared.
module zbuffer_pixel_compositor (
	input  logic        clk,
	input  logic        arst_n,
	zbpc_req_if.sink    req,
	zbpc_rsp_if.source  rsp,
	zbpc_cfg_if.sink    cfg
);
	import zbpc_pkg::*;

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [DIM_W-1:0]   w_eff;
	logic [DIM_W-1:0]   h_eff;
	logic [DIM_W:0]     stride;
	logic [DIM_W-1:0]   row;
	logic [PROD_W-1:0]  lin;
	logic [ADDR_W-1:0]  rd_addr;
	logic               in_oor;
	logic               load_s1;
	logic               commit;

	logic               s1_valid_q;
	logic [OP_W-1:0]    s1_op;
	logic [COLOR_W-1:0] s1_src;
	logic [DEPTH_W-1:0] s1_dval;
	logic [ADDR_W-1:0]  s1_addr;
	logic               s1_oor;

	logic               fwd_c_en_q;
	logic               fwd_d_en_q;
	logic [ADDR_W-1:0]  fwd_addr_q;
	logic [COLOR_W-1:0] fwd_color_q;
	logic [DEPTH_W-1:0] fwd_depth_q;

	logic [COLOR_W-1:0] c_rdata;
	logic [DEPTH_W-1:0] d_rdata;
	logic [COLOR_W-1:0] cur_color;
	logic [DEPTH_W-1:0] cur_depth;
	logic [COLOR_W-1:0] new_color;
	logic [DEPTH_W-1:0] new_depth;
	logic               c_wr_req;
	logic               d_wr_req;
	logic               c_we;
	logic               d_we;

	logic               s2_valid_q;
	logic [COLOR_W-1:0] s2_color;
	logic [DEPTH_W-1:0] s2_depth;
	logic               s2_written;
	logic               s2_oor;

	// Frame size registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_WIDTH_RST;
			height_q <= FRAME_HEIGHT_RST;
		end else if (cfg.valid) begin
			if (cfg.index == REG_FRAME_WIDTH) begin
				width_q <= cfg.data;
			end else if (cfg.index == REG_FRAME_HEIGHT) begin
				height_q <= cfg.data;
			end
		end
	end

	// Effective geometry: sizes saturate to 1..MAX
	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (width_q > DIM_W'(MAX_WIDTH)) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign stride = ((DIM_W + 1)'(w_eff) + (DIM_W + 1)'(3)) & ~(DIM_W + 1)'(3);

	// Address of the request: rows stored bottom-up
	assign in_oor  = (DIM_W'(req.x_pos) >= w_eff) || (DIM_W'(req.y_pos) >= h_eff);
	assign row     = h_eff - DIM_W'(1) - DIM_W'(req.y_pos);
	assign lin     = PROD_W'(row) * PROD_W'(stride) + PROD_W'(req.x_pos);
	assign rd_addr = (lin >= PROD_W'(BUF_SIZE)) ? '0 : lin[ADDR_W-1:0];

	// Handshake: stage 1 drains into the output register
	assign commit    = s1_valid_q && (!s2_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || commit;
	assign load_s1   = req.valid && req.ready;

	// Stage 1: request held while its RAM read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (load_s1) begin
			s1_valid_q <= 1'b1;
		end else if (commit) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			s1_op   <= req.opcode;
			s1_src  <= req.src_color;
			s1_dval <= req.depth_value;
			s1_addr <= rd_addr;
			s1_oor  <= in_oor;
		end
	end

	// Forward entry: the write made at the edge the current request loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_c_en_q <= 1'b0;
			fwd_d_en_q <= 1'b0;
		end else if (load_s1) begin
			fwd_c_en_q <= c_we;
			fwd_d_en_q <= d_we;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			fwd_addr_q  <= s1_addr;
			fwd_color_q <= new_color;
			fwd_depth_q <= new_depth;
		end
	end

	// Frame memories
	zbpc_ram #(.WIDTH(COLOR_W), .DEPTH(BUF_SIZE)) u_color_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (s1_addr),
		.wdata (new_color),
		.re    (load_s1),
		.raddr (rd_addr),
		.rdata (c_rdata)
	);

	zbpc_ram #(.WIDTH(DEPTH_W), .DEPTH(BUF_SIZE)) u_depth_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (s1_addr),
		.wdata (new_depth),
		.re    (load_s1),
		.raddr (rd_addr),
		.rdata (d_rdata)
	);

	// Stored pixel, with the forward entry's write forwarded on an address match
	assign cur_color = (fwd_c_en_q && fwd_addr_q == s1_addr) ? fwd_color_q : c_rdata;
	assign cur_depth = (fwd_d_en_q && fwd_addr_q == s1_addr) ? fwd_depth_q : d_rdata;

	// Operation and depth test
	always_comb begin
		new_color = cur_color;
		new_depth = cur_depth;
		c_wr_req  = 1'b0;
		d_wr_req  = 1'b0;
		if (!s1_oor) begin
			unique case (s1_op)
				OP_FILL: begin
					new_depth = s1_dval;
					d_wr_req  = 1'b1;
				end
				OP_DEPTH: begin
					if (cur_depth >= s1_dval) begin
						new_color = s1_src;
						new_depth = s1_dval;
						c_wr_req  = 1'b1;
						d_wr_req  = 1'b1;
					end
				end
				OP_FLAT: begin
					if (s1_src != '0 && cur_depth > s1_dval) begin
						new_color = s1_src;
						c_wr_req  = 1'b1;
					end
				end
				OP_READ: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign c_we = commit && c_wr_req;
	assign d_we = commit && d_wr_req;

	// Stage 2: response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (commit) begin
			s2_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			s2_color   <= s1_oor ? '0 : new_color;
			s2_depth   <= s1_oor ? '0 : new_depth;
			s2_written <= c_wr_req || d_wr_req;
			s2_oor     <= s1_oor;
		end
	end

	assign rsp.valid        = s2_valid_q;
	assign rsp.pixel_color  = s2_color;
	assign rsp.pixel_depth  = s2_depth;
	assign rsp.was_written  = s2_written;
	assign rsp.out_of_range = s2_oor;

	// Checks
	a_no_write_oor: assert property (@(posedge clk) disable iff (!arst_n)
		(c_we || d_we) |-> (s1_valid_q && !s1_oor))
		else $error("frame RAM written for an out-of-frame request");

	a_fill_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && !s1_oor && s1_op == OP_FILL) |=> (rsp.valid && rsp.was_written))
		else $error("in-frame fill did not report a write");

	a_oor_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && s1_oor) |=> (rsp.valid && !rsp.was_written && rsp.pixel_depth == '0))
		else $error("out-of-frame response carries pixel data");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !commit) |=> (s1_valid_q && $stable(s1_addr)))
		else $error("stalled request lost its address");

endmodule
